// ===== rtl/vbd_pkg.sv =====
// ----------------------------------------------------------------------------
// vbd_pkg
// Shared types, codes and helpers of the VP8 boolean decoder core.
// ----------------------------------------------------------------------------
package vbd_pkg;

   // default depth of the stream bit queue
   localparam int BUFFER_BITS_DEF = 64;

   // command codes on the request channel
   localparam logic [1:0] CMD_PUSH   = 2'd0;
   localparam logic [1:0] CMD_START  = 2'd1;
   localparam logic [1:0] CMD_DECODE = 2'd2;

   // status codes on the response channel
   localparam logic [1:0] STAT_OK       = 2'd0;
   localparam logic [1:0] STAT_NO_DATA  = 2'd1;
   localparam logic [1:0] STAT_DROPPED  = 2'd2;

   // arithmetic constants of the scheme
   localparam logic [7:0] RANGE_INIT = 8'd255;
   localparam logic [3:0] WINDOW_FULL = 4'd8;
   localparam logic [3:0] MAX_LITERAL = 4'd8;

   // sequencer states
   typedef enum logic [1:0] {
      ST_IDLE,
      ST_FETCH,
      ST_RESOLVE,
      ST_DONE
   } state_type;

   // control word from the sequencer to the bit queue
   typedef struct packed {
      logic       push;
      logic [7:0] push_byte;
      logic       take;
      logic [3:0] count;
   } q_ctrl_type;

   // status word from the bit queue to the sequencer
   typedef struct packed {
      logic       full;
      logic       enough;
      logic [7:0] bits;
   } q_stat_type;

   // leading zero count of a nonzero byte
   function automatic logic [2:0] lead_zeros(input logic [7:0] v);
      logic [2:0] n;
      logic       found;
      n = 3'd0;
      found = 1'b0;
      for (int i = 7; i >= 0; i--) begin
         if (!found) begin
            if (v[i]) begin
               found = 1'b1;
            end else begin
               n = n + 3'd1;
            end
         end
      end
      return n;
   endfunction

endpackage

// ===== rtl/vbd_if.sv =====
// ----------------------------------------------------------------------------
// vbd_req_if / vbd_rsp_if
// Valid/ready channels of the VP8 boolean decoder core.
// ----------------------------------------------------------------------------
interface vbd_req_if;
   logic       valid;
   logic       ready;
   logic [1:0] command;
   logic [7:0] stream_byte;
   logic [7:0] probability;
   logic [3:0] literal_width;
   logic       signed_mode;

   modport source (output valid, command, stream_byte, probability, literal_width,
                   signed_mode, input ready);
   modport sink   (input valid, command, stream_byte, probability, literal_width,
                   signed_mode, output ready);
endinterface

interface vbd_rsp_if;
   logic              valid;
   logic              ready;
   logic signed [8:0] decoded_value;
   logic        [1:0] status;

   modport source (output valid, decoded_value, status, input ready);
   modport sink   (input valid, decoded_value, status, output ready);
endinterface

// ===== rtl/vp8_bool_decoder_core.sv =====
// ----------------------------------------------------------------------------
// vp8_bool_decoder_core
// VP8 boolean arithmetic decoder: push bytes, start, decode literals.
//
//   channel  dir  handshake          word
//   req_ch   in   valid/ready        command, stream_byte, probability,
//                                    literal_width, signed_mode
//   rsp_ch   out  valid/ready        decoded_value, status
//
// Push, start and unknown commands go from idle straight to the done state.
// A decode of n bools (width, plus one sign bool in signed mode) passes through
// fetch and resolve for each bool: refill and range multiply in fetch, compare and
// normalize in resolve, through the one shared multiply/compare/shift unit.
// req_ch.ready is high only when idle; a full response register stalls the
// sequencer in its last state. Reset is synchronous and clears control state.
// ----------------------------------------------------------------------------
module vp8_bool_decoder_core #(
   parameter int BUFFER_BITS = vbd_pkg::BUFFER_BITS_DEF
) (
   input  logic      clock,
   input  logic      reset,
   vbd_req_if.sink   req_ch,
   vbd_rsp_if.source rsp_ch
);
   import vbd_pkg::*;

   state_type   state_ff, state_in;
   logic [7:0]  range_ff, range_in;
   logic [7:0]  window_ff, window_in;
   logic [3:0]  wbits_ff, wbits_in;
   logic [15:0] product_ff, product_in;
   logic [7:0]  prob_ff, prob_in;
   logic [3:0]  count_ff, count_in;
   logic        sgn_ff, sgn_in;
   logic        in_sign_ff, in_sign_in;
   logic [7:0]  acc_ff, acc_in;
   logic [8:0]  result_ff, result_in;
   logic [1:0]  status_ff, status_in;
   logic        rsp_valid_ff, rsp_valid_in;
   logic [8:0]  rsp_value_ff, rsp_value_in;
   logic [1:0]  rsp_status_ff, rsp_status_in;

   q_ctrl_type  q_ctrl;
   q_stat_type  q_stat;

   logic        accept;
   logic        fetch_fail;
   logic        last_bool;
   logic        rsp_free;
   logic        empty_decode;
   logic [7:0]  split;
   logic        bool_bit;
   logic [7:0]  range_cut;
   logic [7:0]  window_cut;
   logic [2:0]  norm;
   logic [7:0]  acc_shift;

   vbd_bit_queue #(
      .BUFFER_BITS (BUFFER_BITS)
   ) u_queue (
      .clock (clock),
      .reset (reset),
      .ctrl  (q_ctrl),
      .stat  (q_stat)
   );

   // handshake and shared decisions
   assign req_ch.ready  = (state_ff == ST_IDLE);
   assign accept        = req_ch.valid && req_ch.ready;
   assign rsp_free      = !rsp_valid_ff || rsp_ch.ready;
   assign fetch_fail    = (wbits_ff < WINDOW_FULL) && !q_stat.enough;
   assign last_bool     = in_sign_ff || ((count_ff == 4'd1) && !sgn_ff);
   assign empty_decode  = (req_ch.literal_width == 4'd0) && !req_ch.signed_mode;

   // shared unit: split, compare/subtract, normalize
   assign split      = product_ff[15:8] + 8'd1;
   assign bool_bit   = window_ff >= split;
   assign range_cut  = bool_bit ? (range_ff - split) : split;
   assign window_cut = bool_bit ? (window_ff - split) : window_ff;
   assign norm       = lead_zeros(range_cut);
   assign acc_shift  = {acc_ff[6:0], bool_bit};

   // next state
   always_comb begin
      state_in = state_ff;
      case (state_ff)
         ST_IDLE: begin
            if (accept) begin
               if (req_ch.command == CMD_DECODE && !empty_decode) begin
                  state_in = ST_FETCH;
               end else begin
                  state_in = ST_DONE;
               end
            end
         end
         ST_FETCH: begin
            state_in = fetch_fail ? ST_DONE : ST_RESOLVE;
         end
         ST_RESOLVE: begin
            state_in = last_bool ? ST_DONE : ST_FETCH;
         end
         ST_DONE: begin
            if (rsp_free) begin
               state_in = ST_IDLE;
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   // datapath and queue control
   always_comb begin
      range_in      = range_ff;
      window_in     = window_ff;
      wbits_in      = wbits_ff;
      product_in    = product_ff;
      prob_in       = prob_ff;
      count_in      = count_ff;
      sgn_in        = sgn_ff;
      in_sign_in    = in_sign_ff;
      acc_in        = acc_ff;
      result_in     = result_ff;
      status_in     = status_ff;
      rsp_value_in  = rsp_value_ff;
      rsp_status_in = rsp_status_ff;
      rsp_valid_in  = rsp_valid_ff && !rsp_ch.ready;
      q_ctrl.push      = 1'b0;
      q_ctrl.push_byte = req_ch.stream_byte;
      q_ctrl.take      = 1'b0;
      q_ctrl.count     = WINDOW_FULL - wbits_ff;

      case (state_ff)
         ST_IDLE: begin
            if (accept) begin
               result_in = '0;
               status_in = STAT_OK;
               case (req_ch.command)
                  CMD_PUSH: begin
                     if (q_stat.full) begin
                        status_in = STAT_DROPPED;
                     end else begin
                        q_ctrl.push = 1'b1;
                     end
                  end
                  CMD_START: begin
                     range_in  = RANGE_INIT;
                     window_in = '0;
                     wbits_in  = '0;
                  end
                  CMD_DECODE: begin
                     prob_in    = req_ch.probability;
                     count_in   = (req_ch.literal_width > MAX_LITERAL) ? MAX_LITERAL
                                                                       : req_ch.literal_width;
                     sgn_in     = req_ch.signed_mode;
                     in_sign_in = (req_ch.literal_width == 4'd0);
                     acc_in     = '0;
                  end
                  default: begin
                  end
               endcase
            end
         end
         ST_FETCH: begin
            // refill the window, then register the range product
            if (wbits_ff < WINDOW_FULL) begin
               if (q_stat.enough) begin
                  window_in   = window_ff | q_stat.bits;
                  wbits_in    = WINDOW_FULL;
                  q_ctrl.take = 1'b1;
               end else begin
                  result_in = '0;
                  status_in = STAT_NO_DATA;
               end
            end
            product_in = 16'(range_ff - 8'd1) * 16'(prob_ff);
         end
         ST_RESOLVE: begin
            range_in  = range_cut << norm;
            window_in = window_cut << norm;
            wbits_in  = wbits_ff - 4'(norm);
            if (in_sign_ff) begin
               result_in = bool_bit ? (9'd0 - {1'b0, acc_ff}) : {1'b0, acc_ff};
            end else begin
               acc_in   = acc_shift;
               count_in = count_ff - 4'd1;
               if (count_ff == 4'd1) begin
                  if (sgn_ff) begin
                     in_sign_in = 1'b1;
                  end else begin
                     result_in = {1'b0, acc_shift};
                  end
               end
            end
         end
         ST_DONE: begin
            if (rsp_free) begin
               rsp_valid_in  = 1'b1;
               rsp_value_in  = result_ff;
               rsp_status_in = status_ff;
            end
         end
         default: begin
         end
      endcase
   end

   // control registers
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_IDLE;
         range_ff     <= RANGE_INIT;
         window_ff    <= '0;
         wbits_ff     <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         range_ff     <= range_in;
         window_ff    <= window_in;
         wbits_ff     <= wbits_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   // working and payload registers
   always_ff @(posedge clock) begin
      product_ff    <= product_in;
      prob_ff       <= prob_in;
      count_ff      <= count_in;
      sgn_ff        <= sgn_in;
      in_sign_ff    <= in_sign_in;
      acc_ff        <= acc_in;
      result_ff     <= result_in;
      status_ff     <= status_in;
      rsp_value_ff  <= rsp_value_in;
      rsp_status_ff <= rsp_status_in;
   end

   assign rsp_ch.valid         = rsp_valid_ff;
   assign rsp_ch.decoded_value = $signed(rsp_value_ff);
   assign rsp_ch.status        = rsp_status_ff;

   // window never holds more than one byte of bits
   a_wbits_max: assert property (@(posedge clock) disable iff (reset)
      wbits_ff <= WINDOW_FULL)
      else $error("value window bit count above eight");

   // range is normalized after every bool
   a_range_norm: assert property (@(posedge clock) disable iff (reset)
      (state_ff == ST_RESOLVE) |=> range_ff[7])
      else $error("range not normalized after bool");

   // a failed or dropped word carries a zero value
   a_err_zero: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid_ff && (rsp_status_ff != STAT_OK)) |-> (rsp_value_ff == 9'd0))
      else $error("error word with nonzero value");

   // a refill is taken only when enough bits are queued
   a_take_ok: assert property (@(posedge clock) disable iff (reset)
      q_ctrl.take |-> (q_stat.enough && (state_ff == ST_FETCH)))
      else $error("queue take without enough bits");

endmodule

// ===== rtl/vbd_bit_queue.sv =====
// ----------------------------------------------------------------------------
// vbd_bit_queue
// Stream bit queue: bytes enter at the low end, the oldest bits leave first.
// ----------------------------------------------------------------------------
module vbd_bit_queue #(
   parameter int BUFFER_BITS = vbd_pkg::BUFFER_BITS_DEF
) (
   input  logic                clock,
   input  logic                reset,
   input  vbd_pkg::q_ctrl_type ctrl,
   output vbd_pkg::q_stat_type stat
);
   import vbd_pkg::*;

   localparam int FILL_W = $clog2(BUFFER_BITS + 1);

   logic [BUFFER_BITS-1:0] buf_ff, buf_in;
   logic [FILL_W-1:0]      fill_ff, fill_in;
   logic [FILL_W-1:0]      need;
   logic [FILL_W-1:0]      shift;
   logic [BUFFER_BITS-1:0] shifted;

   // oldest bits sit just below the fill mark
   assign need    = FILL_W'(ctrl.count);
   assign shift   = fill_ff - need;
   assign shifted = buf_ff >> shift;

   assign stat.full   = fill_ff > FILL_W'(BUFFER_BITS - 8);
   assign stat.enough = fill_ff >= need;
   assign stat.bits   = shifted[7:0] & (8'hFF >> (4'd8 - ctrl.count));

   // next queue contents
   always_comb begin
      buf_in  = buf_ff;
      fill_in = fill_ff;
      if (ctrl.push) begin
         buf_in  = {buf_ff[BUFFER_BITS-9:0], ctrl.push_byte};
         fill_in = fill_ff + FILL_W'(8);
      end else if (ctrl.take) begin
         fill_in = shift;
      end
   end

   // contents need no reset: only queued bits are read
   always_ff @(posedge clock) begin
      buf_ff <= buf_in;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         fill_ff <= '0;
      end else begin
         fill_ff <= fill_in;
      end
   end

endmodule

// ===== sim/vp8_bool_decoder_core_test.sv =====
// ----------------------------------------------------------------------------
// vp8_bool_decoder_core_test
// Self-checking bench for the VP8 boolean decoder core. Push, start and
// decode commands go in on the request channel with random gaps. A scoreboard
// keeps its own copy of the bit queue, range and value window, predicts every
// response word and compares it field by field as the responses drain under
// random back-pressure.
// ----------------------------------------------------------------------------
module vp8_bool_decoder_core_test;
   import vbd_pkg::*;

   // spare command code, decoded by the core as a no-op
   localparam logic [1:0] CMD_SPARE = 2'd3;
   localparam int RANDOM_ITEMS   = 400;
   localparam int DRAIN_CYCLES   = 40;
   localparam int WATCHDOG_LIMIT = 2000;

   typedef struct packed {
      logic [1:0] command;
      logic [7:0] stream_byte;
      logic [7:0] probability;
      logic [3:0] literal_width;
      logic       signed_mode;
   } request_word_type;

   typedef struct {
      logic signed [8:0] value;
      logic        [1:0] status;
   } result_word_type;

   // --------------------------------------------------------------------------
   // Scoreboard: bit-exact decoder state plus the queue of pending results
   // --------------------------------------------------------------------------
   class decode_scoreboard_type;
      logic [7:0]  range_q     = RANGE_INIT;
      logic [7:0]  window_q    = 8'd0;
      int          window_bits = 0;
      logic [63:0] stream_q    = 64'd0;
      int          fill_bits   = 0;
      result_word_type pending_results[$];
      int errors     = 0;
      int n_push     = 0;
      int n_dropped  = 0;
      int n_start    = 0;
      int n_decode   = 0;
      int n_starved  = 0;
      int n_negative = 0;
      int n_checked  = 0;

      // one bool: refill window, split range, normalize; 0 when out of bits
      function bit next_bool(input logic [7:0] prob, output bit b);
         int need;
         int shift;
         int split;
         b = 1'b0;
         if (window_bits < 8) begin
            need = 8 - window_bits;
            if (fill_bits < need) return 1'b0;
            shift = fill_bits - need;
            window_q = window_q | 8'((stream_q >> shift) & ((64'd1 << need) - 64'd1));
            fill_bits = shift;
            window_bits = 8;
         end
         split = 1 + (((int'(range_q) - 1) * int'(prob)) >> 8);
         if (int'(window_q) >= split) begin
            b = 1'b1;
            range_q = 8'(int'(range_q) - split);
            window_q = 8'(int'(window_q) - split);
         end else begin
            range_q = 8'(split);
         end
         while (range_q < 8'd128) begin
            window_q = window_q << 1;
            range_q = range_q << 1;
            window_bits--;
         end
         return 1'b1;
      endfunction

      // accepted request: advance state, queue the predicted response
      function void note_command(request_word_type w);
         result_word_type r;
         int         width;
         bit         b;
         bit         ok;
         logic [8:0] mag;
         r.value = '0;
         r.status = STAT_OK;
         case (w.command)
            CMD_PUSH: begin
               n_push++;
               if (fill_bits + 8 > BUFFER_BITS_DEF) begin
                  r.status = STAT_DROPPED;
                  n_dropped++;
               end else begin
                  stream_q = {stream_q[55:0], w.stream_byte};
                  fill_bits += 8;
               end
            end
            CMD_START: begin
               n_start++;
               range_q = RANGE_INIT;
               window_q = 8'd0;
               window_bits = 0;
            end
            CMD_DECODE: begin
               n_decode++;
               width = (w.literal_width > MAX_LITERAL) ? MAX_LITERAL : w.literal_width;
               ok = 1'b1;
               mag = '0;
               for (int i = 0; i < width && ok; i++) begin
                  ok = next_bool(w.probability, b);
                  if (ok) mag = {mag[7:0], b};
               end
               if (ok && w.signed_mode) begin
                  ok = next_bool(w.probability, b);
                  if (ok && b) mag = -mag;
               end
               if (!ok) begin
                  mag = '0;
                  r.status = STAT_NO_DATA;
                  n_starved++;
               end
               if (mag[8]) n_negative++;
               r.value = mag;
            end
            default: ;
         endcase
         pending_results.push_back(r);
      endfunction

      // accepted response: compare with the oldest prediction
      function void check_result(logic signed [8:0] value, logic [1:0] status);
         result_word_type e;
         if (pending_results.size() == 0) begin
            errors++;
            $error("unexpected response word: decoded_value %0d status %0d", value, status);
            return;
         end
         e = pending_results.pop_front();
         n_checked++;
         if (value !== e.value) begin
            errors++;
            $error("decoded_value: expected %0d, actual %0d", e.value, value);
         end
         if (status !== e.status) begin
            errors++;
            $error("status: expected %0d, actual %0d", e.status, status);
         end
      endfunction
   endclass

   // --------------------------------------------------------------------------
   // Clock, reset, channels, core
   // --------------------------------------------------------------------------
   logic clock = 1'b0;
   logic reset = 1'b1;

   always begin
      #5 clock = 1'b1;
      #5 clock = 1'b0;
   end

   vbd_req_if req_ch ();
   vbd_rsp_if rsp_ch ();

   vp8_bool_decoder_core u_dut (
      .clock  (clock),
      .reset  (reset),
      .req_ch (req_ch),
      .rsp_ch (rsp_ch)
   );

   decode_scoreboard_type sb = new;
   bit req_burst  = 1'b0;
   bit rsp_burst  = 1'b0;
   int sent_items = 0;
   int idle_cycles = 0;

   function automatic request_word_type word_of(logic [1:0] cmd, logic [7:0] data,
                                                logic [7:0] prob, logic [3:0] width,
                                                logic sgn);
      request_word_type w;
      w.command = cmd;
      w.stream_byte = data;
      w.probability = prob;
      w.literal_width = width;
      w.signed_mode = sgn;
      return w;
   endfunction

   // request word with the given command, all other fields random
   function automatic request_word_type random_word(logic [1:0] cmd);
      return word_of(cmd, 8'($urandom), 8'($urandom), 4'($urandom), 1'($urandom));
   endfunction

   function automatic request_word_type random_decode();
      int w;
      w = $urandom_range(0, 9);
      if (w == 9) w = $urandom_range(9, 15);
      return word_of(CMD_DECODE, 8'($urandom), 8'($urandom_range(0, 255)), 4'(w),
                     1'($urandom_range(0, 1)));
   endfunction

   // drive one request word and hold it until the core takes it
   task automatic send_word(input request_word_type w);
      int gap;
      gap = req_burst ? 0 : $urandom_range(0, 8);
      if (gap > 0) begin
         req_ch.valid <= 1'b0;
         repeat (gap) @(posedge clock);
      end
      req_ch.valid <= 1'b1;
      req_ch.command <= w.command;
      req_ch.stream_byte <= w.stream_byte;
      req_ch.probability <= w.probability;
      req_ch.literal_width <= w.literal_width;
      req_ch.signed_mode <= w.signed_mode;
      @(posedge clock);
      while (req_ch.ready !== 1'b1) @(posedge clock);
      sb.note_command(w);
      if (w.command != CMD_SPARE) sent_items++;
   endtask

   // --------------------------------------------------------------------------
   // Response side: random stalls, burst stretches with ready held high
   // --------------------------------------------------------------------------
   initial begin
      int stall;
      rsp_ch.ready <= 1'b0;
      while (reset) @(posedge clock);
      forever begin
         stall = rsp_burst ? 0 : $urandom_range(0, 8);
         if (stall > 0) begin
            rsp_ch.ready <= 1'b0;
            repeat (stall) @(posedge clock);
         end
         rsp_ch.ready <= 1'b1;
         @(posedge clock);
         while (rsp_ch.valid !== 1'b1) @(posedge clock);
         sb.check_result(rsp_ch.decoded_value, rsp_ch.status);
         if ($urandom_range(0, 39) == 0) rsp_burst = !rsp_burst;
      end
   end

   // watchdog on cycles without any accepted word
   always @(posedge clock) begin
      if (reset || (req_ch.valid && req_ch.ready) || (rsp_ch.valid && rsp_ch.ready)) begin
         idle_cycles <= 0;
      end else begin
         idle_cycles <= idle_cycles + 1;
         if (idle_cycles >= WATCHDOG_LIMIT) begin
            $display("vp8_bool_decoder_core_test failed");
            $finish;
         end
      end
   end

   // --------------------------------------------------------------------------
   // Stimulus
   // --------------------------------------------------------------------------
   initial begin
      int pick;
      req_ch.valid <= 1'b0;
      req_ch.command <= CMD_PUSH;
      req_ch.stream_byte <= 8'd0;
      req_ch.probability <= 8'd0;
      req_ch.literal_width <= 4'd0;
      req_ch.signed_mode <= 1'b0;
      repeat (3) @(posedge clock);
      reset <= 1'b0;

      // directed: empty queue, fill to full, drop, spare code, width corners
      send_word(word_of(CMD_DECODE, 8'h00, 8'd128, 4'd1, 1'b0));
      send_word(word_of(CMD_START, 8'hFF, 8'hFF, 4'hF, 1'b1));
      send_word(word_of(CMD_PUSH, 8'h00, 8'h00, 4'h0, 1'b0));
      send_word(word_of(CMD_PUSH, 8'hFF, 8'hFF, 4'hF, 1'b1));
      send_word(word_of(CMD_PUSH, 8'hA5, 8'h00, 4'h0, 1'b0));
      send_word(word_of(CMD_PUSH, 8'h5A, 8'h00, 4'h0, 1'b0));
      send_word(word_of(CMD_PUSH, 8'h3C, 8'h00, 4'h0, 1'b0));
      send_word(word_of(CMD_PUSH, 8'hC3, 8'h00, 4'h0, 1'b0));
      send_word(word_of(CMD_PUSH, 8'h81, 8'h00, 4'h0, 1'b0));
      send_word(word_of(CMD_PUSH, 8'h7E, 8'h00, 4'h0, 1'b0));
      // queue is full now, this byte is dropped
      send_word(word_of(CMD_PUSH, 8'h55, 8'h00, 4'h0, 1'b0));
      send_word(word_of(CMD_SPARE, 8'hFF, 8'hFF, 4'hF, 1'b1));
      send_word(word_of(CMD_DECODE, 8'h00, 8'd200, 4'd0, 1'b0));
      send_word(word_of(CMD_DECODE, 8'h00, 8'd128, 4'd0, 1'b1));
      send_word(word_of(CMD_DECODE, 8'h00, 8'd0, 4'd4, 1'b0));
      send_word(word_of(CMD_DECODE, 8'h00, 8'd255, 4'd8, 1'b0));
      // width above the maximum saturates
      send_word(word_of(CMD_DECODE, 8'h00, 8'd128, 4'd15, 1'b1));
      // drain the queue until a decode runs out of bits
      repeat (6) send_word(word_of(CMD_DECODE, 8'h00, 8'd128, 4'd8, 1'b1));
      send_word(word_of(CMD_START, 8'h00, 8'h00, 4'h0, 1'b0));
      send_word(word_of(CMD_DECODE, 8'h00, 8'd128, 4'd1, 1'b0));

      // random: mostly keep the queue fed and decode, with some noise
      while (sent_items < RANDOM_ITEMS + 25) begin
         if ($urandom_range(0, 59) == 0) req_burst = !req_burst;
         pick = $urandom_range(0, 99);
         if (pick < 4) begin
            send_word(random_word(CMD_START));
         end else if (pick < 6) begin
            send_word(random_word(CMD_SPARE));
         end else if (pick < 10) begin
            send_word(random_word(CMD_PUSH));
         end else if (pick < 16) begin
            send_word(random_decode());
         end else if (sb.fill_bits <= 40) begin
            send_word(random_word(CMD_PUSH));
         end else begin
            send_word(random_decode());
         end
      end
      req_ch.valid <= 1'b0;

      while (sb.pending_results.size() > 0) @(posedge clock);
      repeat (DRAIN_CYCLES) @(posedge clock);

      $display("run covered %0d pushes (%0d dropped), %0d starts, %0d decodes",
               sb.n_push, sb.n_dropped, sb.n_start, sb.n_decode);
      $display("  %0d decodes starved of bits, %0d negative literals, %0d words checked",
               sb.n_starved, sb.n_negative, sb.n_checked);
      if (sb.errors == 0) begin
         $display("vp8_bool_decoder_core_test passed");
      end else begin
         $display("vp8_bool_decoder_core_test failed");
      end
      $finish;
   end

endmodule
